### rtl/core/spc_pkg.sv
// Package: shared codes, state type and controller/datapath structs.
`timescale 1ns / 1ps
package spc_pkg;

   localparam logic [1:0] OP_WRITE_COLOR  = 2'd0;
   localparam logic [1:0] OP_WRITE_HITBOX = 2'd1;
   localparam logic [1:0] OP_QUERY        = 2'd2;
   localparam logic [1:0] OP_RESERVED     = 2'd3;

   localparam logic [2:0] CSR_FIRST_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_FIRST_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_SECOND_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_SECOND_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_TRANSPARENT   = 3'd4;

   localparam logic [6:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic write;   // store one dot from the accepted transaction
      logic start;   // capture query offsets, clear row counter and flag
      logic scan;    // issue one row read pair
   } cmd_type;

   typedef struct packed {
      logic last_row;
   } status_type;

endpackage

### rtl/core/spc_if.sv
// Interfaces: request, response and register write channels.
`timescale 1ns / 1ps
interface spc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic               image_sel;
   logic [5:0]         dot_x;
   logic [5:0]         dot_y;
   logic [3:0]         value;
   logic signed [15:0] first_x;
   logic signed [15:0] first_y;
   logic signed [15:0] second_x;
   logic signed [15:0] second_y;
   logic               mask_mode;
   modport source (output valid, op, image_sel, dot_x, dot_y, value, first_x, first_y,
                   second_x, second_y, mask_mode, input ready);
   modport sink (input valid, op, image_sel, dot_x, dot_y, value, first_x, first_y,
                 second_x, second_y, mask_mode, output ready);
endinterface

interface spc_rsp_if;
   logic valid;
   logic ready;
   logic overlap;
   modport source (output valid, overlap, input ready);
   modport sink (input valid, overlap, output ready);
endinterface

interface spc_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/spc_ctrl.sv
// Controller: transaction handshakes and query sequencing.
`timescale 1ns / 1ps
module spc_ctrl
   import spc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      req_fire;

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_op == OP_QUERY) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.last_row) state_in = ST_FLUSH;
         end
         ST_FLUSH: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.write = req_fire && (req_op inside {OP_WRITE_COLOR, OP_WRITE_HITBOX});
            cmd.start = req_fire && req_op == OP_QUERY;
         end
         ST_SCAN:  cmd.scan = 1'b1;
         ST_FLUSH: ;
         ST_RESP:  rsp_valid = 1'b1;
         default:  ;
      endcase
   end

endmodule

### rtl/core/spc_dp.sv
// Datapath: registers, row-wide sprite memories and the row compare.
`timescale 1ns / 1ps
module spc_dp
   import spc_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_fire,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic [1:0]         op,
   input  logic               image_sel,
   input  logic [5:0]         dot_x,
   input  logic [5:0]         dot_y,
   input  logic [3:0]         value,
   input  logic signed [15:0] first_x,
   input  logic signed [15:0] first_y,
   input  logic signed [15:0] second_x,
   input  logic signed [15:0] second_y,
   input  logic               mask_mode,
   output logic               overlap
);

   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW = MAX_WIDTH * 4;
   localparam logic [8:0] MAX_W_EVEN = 9'(MAX_WIDTH & ~1);
   localparam logic [8:0] MAX_H      = 9'(MAX_HEIGHT);
   localparam logic [YW-1:0] LAST_ROW = YW'(MAX_HEIGHT - 1);

   // configuration
   logic [6:0] first_width_ff, first_height_ff, second_width_ff, second_height_ff;
   logic [3:0] transp_ff;
   logic [8:0] w1, h1, w2, h2;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_width_ff   <= SIZE_RESET;
         first_height_ff  <= SIZE_RESET;
         second_width_ff  <= SIZE_RESET;
         second_height_ff <= SIZE_RESET;
         transp_ff        <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_FIRST_WIDTH:   first_width_ff   <= csr_data;
            CSR_FIRST_HEIGHT:  first_height_ff  <= csr_data;
            CSR_SECOND_WIDTH:  second_width_ff  <= csr_data;
            CSR_SECOND_HEIGHT: second_height_ff <= csr_data;
            CSR_TRANSPARENT:   transp_ff        <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // effective sizes: width rounded down to even, both clamped to the store
   always_comb begin
      w1 = {2'b0, first_width_ff[6:1], 1'b0};
      w2 = {2'b0, second_width_ff[6:1], 1'b0};
      h1 = {2'b0, first_height_ff};
      h2 = {2'b0, second_height_ff};
      if (w1 > MAX_W_EVEN) w1 = MAX_W_EVEN;
      if (w2 > MAX_W_EVEN) w2 = MAX_W_EVEN;
      if (h1 > MAX_H) h1 = MAX_H;
      if (h2 > MAX_H) h2 = MAX_H;
   end

   // dot writes; a row never written reads as all zero
   logic [CW-1:0]        color0_mem [MAX_HEIGHT];
   logic [CW-1:0]        color1_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] hit0_mem   [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0] hit1_mem   [MAX_HEIGHT];
   logic [MAX_HEIGHT-1:0] valid0_ff, valid1_ff;

   logic          wr_ok, wr0, wr1, wr_color, row_valid;
   logic [YW-1:0] wr_row;
   logic [CW-1:0] color_fresh;
   logic [MAX_WIDTH-1:0] hit_fresh;

   assign wr_ok = cmd.write && ({3'b0, dot_x} < (image_sel ? w2 : w1))
                  && ({3'b0, dot_y} < (image_sel ? h2 : h1));
   assign wr0      = wr_ok && !image_sel;
   assign wr1      = wr_ok && image_sel;
   assign wr_color = op == OP_WRITE_COLOR;
   assign wr_row   = YW'(dot_y);
   assign row_valid = image_sel ? valid1_ff[wr_row] : valid0_ff[wr_row];

   always_comb begin
      color_fresh = '0;
      hit_fresh   = '0;
      if (wr_color) color_fresh[dot_x*4 +: 4] = value;
      else          hit_fresh[dot_x] = value[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= '0;
         valid1_ff <= '0;
      end else begin
         if (wr0) valid0_ff[wr_row] <= 1'b1;
         if (wr1) valid1_ff[wr_row] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr0) begin
         if (!row_valid) begin
            color0_mem[wr_row] <= color_fresh;
            hit0_mem[wr_row]   <= hit_fresh;
         end else if (wr_color) begin
            color0_mem[wr_row][dot_x*4 +: 4] <= value;
         end else begin
            hit0_mem[wr_row][dot_x] <= value[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr1) begin
         if (!row_valid) begin
            color1_mem[wr_row] <= color_fresh;
            hit1_mem[wr_row]   <= hit_fresh;
         end else if (wr_color) begin
            color1_mem[wr_row][dot_x*4 +: 4] <= value;
         end else begin
            hit1_mem[wr_row][dot_x] <= value[0];
         end
      end
   end

   // query: one row of sprite zero and the matching row of sprite one per cycle
   logic signed [16:0] offx_ff, offy_ff;
   logic               hit_ff;
   logic [YW-1:0]      row_ff;
   logic               found_ff;
   logic signed [17:0] brow;
   logic               live;
   logic [YW-1:0]      rd1_row;

   assign brow    = $signed(18'(row_ff)) + 18'(offy_ff);
   assign live    = ({1'b0, 8'(row_ff)} < h1) && !brow[17] && (brow < $signed({9'b0, h2}));
   assign rd1_row = brow[YW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         offx_ff <= 17'(first_x) - 17'(second_x);
         offy_ff <= 17'(first_y) - 17'(second_y);
         hit_ff  <= mask_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         row_ff <= '0;
      end else if (cmd.scan) begin
         row_ff <= row_ff + 1'b1;
      end
   end

   assign status.last_row = ({1'b0, 8'(row_ff)} + 9'd1 >= h1) || row_ff == LAST_ROW;

   // registered row reads
   logic [CW-1:0]        c0_rd_ff, c1_rd_ff;
   logic [MAX_WIDTH-1:0] h0_rd_ff, h1_rd_ff;
   logic                 v0_rd_ff, v1_rd_ff, live_ff;

   always_ff @(posedge clock) begin
      c0_rd_ff <= color0_mem[row_ff];
      h0_rd_ff <= hit0_mem[row_ff];
      v0_rd_ff <= valid0_ff[row_ff];
      c1_rd_ff <= color1_mem[rd1_row];
      h1_rd_ff <= hit1_mem[rd1_row];
      v1_rd_ff <= valid1_ff[rd1_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= cmd.scan && live;
      end
   end

   // counted dots of both rows, then align sprite one onto sprite zero columns
   logic [MAX_WIDTH-1:0] mask0, mask1, aligned;
   logic [CW-1:0]        c0, c1;
   logic [MAX_WIDTH-1:0] hb0, hb1;
   logic [16:0]          shamt;
   logic                 in_reach;

   always_comb begin
      c0  = v0_rd_ff ? c0_rd_ff : '0;
      c1  = v1_rd_ff ? c1_rd_ff : '0;
      hb0 = v0_rd_ff ? h0_rd_ff : '0;
      hb1 = v1_rd_ff ? h1_rd_ff : '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         mask0[i] = (9'(i) < w1) && (hit_ff ? hb0[i] : (c0[i*4 +: 4] != transp_ff));
         mask1[i] = (9'(i) < w2) && (hit_ff ? hb1[i] : (c1[i*4 +: 4] != transp_ff));
      end
   end

   assign shamt    = offx_ff[16] ? 17'(-offx_ff) : 17'(offx_ff);
   assign in_reach = shamt < 17'(MAX_WIDTH);
   assign aligned  = !in_reach ? '0 :
                     (offx_ff[16] ? (mask1 << shamt[8:0]) : (mask1 >> shamt[8:0]));

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         found_ff <= 1'b0;
      end else if (live_ff && |(mask0 & aligned)) begin
         found_ff <= 1'b1;
      end
   end

   assign overlap = found_ff;

endmodule

### rtl/core/sprite_pixel_collision.sv
// Top level: pixel-exact collision test between two stored sprites.
// Sequence: a dot write is stored when it is accepted; a query scans the rows of
//   sprite zero (h1, its effective height), then flushes and then raises its response.
// Throughput: one transaction at a time; the query scan reads one row pair per
//   cycle from the row-wide memories, so it is bounded by MAX_HEIGHT rows.
// Reset: synchronous, active high; sizes go to 64, transparent index to 0, and
//   per-row valid bits make every dot read as zero until written.
`timescale 1ns / 1ps
module sprite_pixel_collision
   import spc_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input logic       clock,
   input logic       reset,
   spc_req_if.sink   req_ch,
   spc_rsp_if.source rsp_ch,
   spc_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   // register writes are always taken; the user must send them only while idle, as the block does not enforce it
   assign csr_ch.ready = 1'b1;

   // sequencer: handshakes and row scan stepping
   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, row compare and the sticky overlap flag shown on the response
   spc_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_fire   (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .op         (req_ch.op),
      .image_sel  (req_ch.image_sel),
      .dot_x      (req_ch.dot_x),
      .dot_y      (req_ch.dot_y),
      .value      (req_ch.value),
      .first_x    (req_ch.first_x),
      .first_y    (req_ch.first_y),
      .second_x   (req_ch.second_x),
      .second_y   (req_ch.second_y),
      .mask_mode  (req_ch.mask_mode),
      .overlap    (rsp_ch.overlap)
   );

endmodule
